/* design/tbvp_pkg.sv */
// ----------------------------------------------------------------------------
// tbvp_pkg
// shared types and constants for the tagged bitstream value parser
// ----------------------------------------------------------------------------
package tbvp_pkg;

   localparam int BYTE_BITS = 8;
   localparam int VALUE_W   = 32;
   localparam int RSP_DEPTH = 4;

   // value kinds
   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_INT   = 2'd1;
   localparam logic [1:0] KIND_FLOAT = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   // bit counts per field
   localparam logic [5:0] TYPE_BITS  = 6'd2;
   localparam logic [5:0] CHAR_BITS  = 6'd7;
   localparam logic [5:0] LEN_BITS   = 6'd5;
   localparam logic [5:0] FLOAT_BITS = 6'd32;

   typedef enum logic [2:0] {
      PH_TYPE = 3'b001,
      PH_LEN  = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic [5:0]           bits_rem;
      logic [1:0]           vkind;
      logic [VALUE_W-1:0]   acc;
      logic                 finished;
   } state_type;

   typedef struct packed {
      logic                 last;
      logic [VALUE_W-1:0]   value;
      logic [1:0]           kind;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:    PH_TYPE,
      bits_rem: TYPE_BITS,
      vkind:    KIND_CHAR,
      acc:      '0,
      finished: 1'b0
   };

endpackage

/* design/tbvp_parse.sv */
// ----------------------------------------------------------------------------
// tbvp_parse
// consumes the eight bits of one byte against the parser state
// ----------------------------------------------------------------------------
module tbvp_parse (
   input  logic [tbvp_pkg::BYTE_BITS-1:0] byte_i,
   input  tbvp_pkg::state_type            state_i,
   output tbvp_pkg::state_type            state_o,
   output logic [1:0]                     res_cnt_o,
   output tbvp_pkg::result_type           res_o [2]
);

   always_comb begin
      tbvp_pkg::state_type  st;
      tbvp_pkg::result_type res [2];
      logic [1:0]           cnt;
      logic                 bit_v;
      st     = state_i;
      cnt    = 2'd0;
      res[0] = '0;
      res[1] = '0;
      bit_v  = 1'b0;
      for (int i = 0; i < tbvp_pkg::BYTE_BITS; i++) begin
         if (!st.finished) begin
            bit_v  = byte_i[3'(tbvp_pkg::BYTE_BITS - 1 - i)];
            st.acc = {st.acc[tbvp_pkg::VALUE_W-2:0], bit_v};
            if (st.bits_rem != 6'd0) begin
               st.bits_rem = st.bits_rem - 6'd1;
            end
            if (st.bits_rem == 6'd0) begin
               unique case (st.phase)
                  tbvp_pkg::PH_LEN: begin
                     st.bits_rem = {1'b0, st.acc[4:0]} + 6'd1;
                     st.acc      = '0;
                     st.phase    = tbvp_pkg::PH_DATA;
                  end
                  tbvp_pkg::PH_DATA: begin
                     if (cnt != 2'd2) begin
                        res[cnt[0]].kind  = st.vkind;
                        res[cnt[0]].value = st.acc;
                        cnt               = cnt + 2'd1;
                     end
                     st.acc      = '0;
                     st.phase    = tbvp_pkg::PH_TYPE;
                     st.bits_rem = tbvp_pkg::TYPE_BITS;
                  end
                  default: begin
                     st.vkind = st.acc[1:0];
                     st.acc   = '0;
                     unique case (st.vkind)
                        tbvp_pkg::KIND_CHAR: begin
                           st.phase    = tbvp_pkg::PH_DATA;
                           st.bits_rem = tbvp_pkg::CHAR_BITS;
                        end
                        tbvp_pkg::KIND_INT: begin
                           st.phase    = tbvp_pkg::PH_LEN;
                           st.bits_rem = tbvp_pkg::LEN_BITS;
                        end
                        tbvp_pkg::KIND_FLOAT: begin
                           st.phase    = tbvp_pkg::PH_DATA;
                           st.bits_rem = tbvp_pkg::FLOAT_BITS;
                        end
                        tbvp_pkg::KIND_END: begin
                           if (cnt != 2'd2) begin
                              res[cnt[0]].kind  = tbvp_pkg::KIND_END;
                              res[cnt[0]].value = '0;
                              cnt               = cnt + 2'd1;
                           end
                           st.finished = 1'b1;
                           st.phase    = tbvp_pkg::PH_TYPE;
                           st.bits_rem = tbvp_pkg::TYPE_BITS;
                        end
                     endcase
                  end
               endcase
            end
         end
      end
      if (cnt == 2'd1) begin
         res[0].last = 1'b1;
      end
      if (cnt == 2'd2) begin
         res[1].last = 1'b1;
      end
      state_o   = st;
      res_cnt_o = cnt;
      res_o     = res;
   end

endmodule

/* design/tbvp_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// tbvp_rsp_fifo
// result queue taking up to two words per cycle and giving one
// ----------------------------------------------------------------------------
module tbvp_rsp_fifo #(
   parameter int DEPTH = tbvp_pkg::RSP_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_cnt,
   input  tbvp_pkg::result_type push_data [2],
   output logic                 room,
   input  logic                 pop,
   output logic                 valid,
   output tbvp_pkg::result_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   tbvp_pkg::result_type mem_ff [DEPTH];
   tbvp_pkg::result_type mem_in [DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr1;
   logic [CW-1:0]        count_ff, count_in;
   logic                 do_pop;

   function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign valid  = (count_ff != '0);
   assign head   = mem_ff[rd_ptr_ff];
   assign room   = (count_ff <= CW'(DEPTH - 2));
   assign do_pop = pop && valid;
   assign wr_ptr1 = inc(wr_ptr_ff);

   always_comb begin
      mem_in = mem_ff;
      for (int i = 0; i < DEPTH; i++) begin
         if (push_cnt != 2'd0 && wr_ptr_ff == PW'(i)) begin
            mem_in[i] = push_data[0];
         end
         if (push_cnt == 2'd2 && wr_ptr1 == PW'(i)) begin
            mem_in[i] = push_data[1];
         end
      end
      unique case (push_cnt)
         2'd0:    wr_ptr_in = wr_ptr_ff;
         2'd1:    wr_ptr_in = wr_ptr1;
         default: wr_ptr_in = inc(wr_ptr1);
      endcase
      rd_ptr_in = do_pop ? inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push_cnt) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("result queue overfilled");
`endif

endmodule

/* design/tagged_bitstream_value_parser.sv */
// ----------------------------------------------------------------------------
// tagged_bitstream_value_parser
// decodes a byte stream of 2-bit tagged values into result words
// ----------------------------------------------------------------------------
// usage:
//   req_* takes one stream byte per word, bit 7 consumed first.
//   rsp_* gives one decoded value per word: kind in tdata[1:0], value in
//   tdata[33:2], tlast on the final result caused by one input byte.
//   a byte yields zero, one or two results (a value plus the end marker).
// timing:
//   a byte is held in the input register, its eight bits are parsed
//   combinationally and the results are written into the result queue,
//   whose registered head drives rsp_*.
//   throughput is one byte per cycle while the queue has room for two
//   results; the parse of the input register is combinational.
// reset:
//   parser goes back to reading a type tag, queue and input stage empty.
//   after the end marker bytes are still taken but give no results.
// stall:
//   a stalled receiver fills the result queue; req_tready drops once the
//   queue can no longer take two results and the input register is full.
// ----------------------------------------------------------------------------
module tagged_bitstream_value_parser #(
   parameter int DEPTH = tbvp_pkg::RSP_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // kind[1:0], value[33:2], zero[39:34]
   output logic        rsp_tlast
);

   logic [tbvp_pkg::BYTE_BITS-1:0] byte_ff;
   logic                           byte_vld_ff, byte_vld_in;
   tbvp_pkg::state_type            state_ff, state_in, state_nx;
   tbvp_pkg::result_type           res [2];
   tbvp_pkg::result_type           head;
   logic [1:0]                     res_cnt, push_cnt;
   logic                           room, advance;

   tbvp_parse u_parse (
      .byte_i    (byte_ff),
      .state_i   (state_ff),
      .state_o   (state_nx),
      .res_cnt_o (res_cnt),
      .res_o     (res)
   );

   assign advance     = byte_vld_ff && room;
   assign req_tready  = !byte_vld_ff || room;
   assign byte_vld_in = (req_tvalid && req_tready) || (byte_vld_ff && !advance);
   assign state_in    = advance ? state_nx : state_ff;
   assign push_cnt    = advance ? res_cnt : 2'd0;

   tbvp_rsp_fifo #(
      .DEPTH (DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_data (res),
      .room      (room),
      .pop       (rsp_tready),
      .valid     (rsp_tvalid),
      .head      (head)
   );

   assign rsp_tdata = {6'd0, head.value, head.kind};
   assign rsp_tlast = head.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
         state_ff    <= tbvp_pkg::STATE_RESET;
      end else begin
         byte_vld_ff <= byte_vld_in;
         state_ff    <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_finished_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff.finished |=> state_ff.finished)
      else $error("end of stream flag cleared without reset");

   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      state_ff.finished |-> res_cnt == 2'd0)
      else $error("result produced after end of stream");

   a_second_is_end: assert property (@(posedge clock) disable iff (reset)
      res_cnt == 2'd2 |-> res[1].kind == tbvp_pkg::KIND_END && !res[0].last
                          && res[1].last)
      else $error("two results from one byte without end marker");

   a_end_sets_finished: assert property (@(posedge clock) disable iff (reset)
      (advance && res_cnt != 2'd0 && res[res_cnt[1]].kind == tbvp_pkg::KIND_END)
      |=> state_ff.finished)
      else $error("end marker emitted without finishing");
`endif

endmodule
